FILE: hdl/bcero_pkg.sv
package bcero_pkg;

   localparam int PIXEL_WIDTH     = 8;
   localparam int OUT_ROW_WIDTH   = 12;
   localparam int OUT_COL_WIDTH   = 11;
   localparam int COLS_WIDTH      = 12;
   localparam int ROWS_WIDTH      = 13;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 13;
   localparam int RSP_DEPTH       = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_COLS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ROWS = CSR_INDEX_WIDTH'(1);

   localparam logic [COLS_WIDTH-1:0] COLS_RESET = COLS_WIDTH'(640);
   localparam logic [ROWS_WIDTH-1:0] ROWS_RESET = ROWS_WIDTH'(480);

   localparam logic [PIXEL_WIDTH-1:0] PIXEL_ON  = PIXEL_WIDTH'(255);
   localparam logic [PIXEL_WIDTH-1:0] PIXEL_OFF = PIXEL_WIDTH'(0);

   localparam logic REQ_PIXEL = 1'b0;

   typedef struct packed {
      logic                   req_type;
      logic [PIXEL_WIDTH-1:0] pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0]   pixel_out;
      logic [OUT_ROW_WIDTH-1:0] out_row;
      logic [OUT_COL_WIDTH-1:0] out_col;
      logic                     last_of_frame;
   } rsp_payload_type;

endpackage

FILE: hdl/binary_cross_erosion_5x5.sv
// Binary 5x5 cross erosion on a raster pixel stream. Pixels of a frame_rows x frame_cols
// frame enter in raster order, one transaction per clock while the result queue has room;
// from the third row on each pixel transaction yields one output pixel two rows behind it
// (0 or 255, the border two pixels deep is 255); the result is registered in the second
// stage and then written to the result queue, whose occupancy drives rsp_valid.
// The four previous rows live in one MAX_COLS x 4 bit RAM with a registered read, read
// two columns ahead and written back once per pixel, which sets the one-per-clock figure.
// After the last pixel of a frame, each further transaction (flush or pixel) drains one
// tail output of 255 until the one marked last_of_frame; flushes sent earlier are dropped.
// Writing frame_cols or frame_rows restarts the frame. The RAM needs no clearing after
// reset. Frames narrower than five columns give no interior pixels.
module binary_cross_erosion_5x5
   import bcero_pkg::*;
#(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int RIW = $clog2(MAX_ROWS);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int PW  = $clog2(RSP_DEPTH);
   localparam int QCW = $clog2(RSP_DEPTH + 1);

   // configuration
   logic [COLS_WIDTH-1:0] frame_cols_ff, frame_cols_in;
   logic [ROWS_WIDTH-1:0] frame_rows_ff, frame_rows_in;
   logic [NCW-1:0]        num_cols;
   logic [RW-1:0]         num_rows;

   // frame position
   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in;
   logic [CW-1:0]  emit_col_ff, emit_col_in;
   logic [RIW-1:0] emit_row_ff, emit_row_in;
   logic           draining_ff, draining_in;

   // line store and column window
   logic [3:0]    line_store [MAX_COLS];
   logic [3:0]    rd_data_ff;
   logic [3:0]    window_ff [4];
   logic [CW-1:0] rd_addr;
   logic [NCW:0]  rd_next;

   // second stage
   logic           s2_result_ff, s2_result_in;
   logic           s2_shift_ff, s2_shift_in;
   logic           s2_inner_ff;
   logic           s2_bit_ff;
   logic [CW-1:0]  s2_col_ff;
   logic [RIW-1:0] s2_row_ff;
   logic [CW-1:0]  s2_emit_col_ff;
   logic           s2_last_ff;

   // result queue
   rsp_payload_type rsp_queue_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]  count_ff, count_in;
   logic [QCW:0]    pending;

   logic           accept;
   logic           pixel_item;
   logic           pixel_bit;
   logic           do_emit;
   logic           do_store;
   logic           inner;
   logic           last;
   logic [RW:0]    row_plus1;
   logic [RW:0]    row_plus2;
   logic [NCW:0]   col_plus1;
   logic [NCW:0]   col_plus2;
   logic [NCW:0]   in_col_plus1;
   logic [RW:0]    in_row_plus1;
   logic [4:0]     center_row_window;
   logic           vert;
   logic           push;
   logic           pop;
   rsp_payload_type s2_rsp;

   always_comb begin
      if (frame_cols_ff == '0) begin
         num_cols = NCW'(1);
      end else if (32'(frame_cols_ff) > 32'(MAX_COLS)) begin
         num_cols = NCW'(MAX_COLS);
      end else begin
         num_cols = NCW'(frame_cols_ff);
      end
      if (frame_rows_ff == '0) begin
         num_rows = RW'(1);
      end else if (32'(frame_rows_ff) > 32'(MAX_ROWS)) begin
         num_rows = RW'(MAX_ROWS);
      end else begin
         num_rows = RW'(frame_rows_ff);
      end
   end

   assign pending   = (QCW+1)'(count_ff) + (QCW+1)'(s2_result_ff);
   assign req_ready = pending < (QCW+1)'(RSP_DEPTH);
   assign accept    = req_valid && req_ready;

   assign pixel_item = (req_data.req_type == REQ_PIXEL);
   assign pixel_bit  = (req_data.pixel_in != '0);
   assign do_emit    = draining_ff || (pixel_item && in_row_ff >= RW'(2));
   assign do_store   = !draining_ff && pixel_item;

   assign row_plus1    = (RW+1)'(emit_row_ff) + (RW+1)'(1);
   assign row_plus2    = (RW+1)'(emit_row_ff) + (RW+1)'(2);
   assign col_plus1    = (NCW+1)'(emit_col_ff) + (NCW+1)'(1);
   assign col_plus2    = (NCW+1)'(emit_col_ff) + (NCW+1)'(2);
   assign in_col_plus1 = (NCW+1)'(in_col_ff) + (NCW+1)'(1);
   assign in_row_plus1 = (RW+1)'(in_row_ff) + (RW+1)'(1);

   assign inner = !draining_ff
                  && emit_row_ff >= RIW'(2) && row_plus2 < (RW+1)'(num_rows)
                  && emit_col_ff >= CW'(2) && col_plus2 < (NCW+1)'(num_cols);
   assign last  = row_plus1 >= (RW+1)'(num_rows) && col_plus1 >= (NCW+1)'(num_cols);

   // prefetch two columns ahead, wrapping into the next row
   assign rd_next = (NCW+1)'(in_col_ff) + (NCW+1)'(2);
   assign rd_addr = (rd_next < (NCW+1)'(num_cols)) ? CW'(rd_next)
                                                   : CW'(rd_next - (NCW+1)'(num_cols));

   always_comb begin
      frame_cols_in = frame_cols_ff;
      frame_rows_in = frame_rows_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      emit_col_in   = emit_col_ff;
      emit_row_in   = emit_row_ff;
      draining_in   = draining_ff;
      s2_result_in  = accept && do_emit;
      s2_shift_in   = accept && do_store;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_COLS: frame_cols_in = csr_wdata[COLS_WIDTH-1:0];
            CSR_FRAME_ROWS: frame_rows_in = csr_wdata[ROWS_WIDTH-1:0];
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         emit_col_in = '0;
         emit_row_in = '0;
         draining_in = 1'b0;
      end else if (accept) begin
         if (do_store) begin
            if (in_col_plus1 >= (NCW+1)'(num_cols)) begin
               in_col_in = '0;
               if (in_row_plus1 >= (RW+1)'(num_rows)) begin
                  in_row_in   = num_rows;
                  draining_in = 1'b1;
               end else begin
                  in_row_in = RW'(in_row_plus1);
               end
            end else begin
               in_col_in = CW'(in_col_plus1);
            end
         end
         if (do_emit) begin
            if (last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               emit_col_in = '0;
               emit_row_in = '0;
               draining_in = 1'b0;
            end else if (col_plus1 >= (NCW+1)'(num_cols)) begin
               emit_col_in = '0;
               emit_row_in = RIW'(row_plus1);
            end else begin
               emit_col_in = CW'(col_plus1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff <= COLS_RESET;
         frame_rows_ff <= ROWS_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         emit_col_ff   <= '0;
         emit_row_ff   <= '0;
         draining_ff   <= 1'b0;
         s2_result_ff  <= 1'b0;
         s2_shift_ff   <= 1'b0;
      end else begin
         frame_cols_ff <= frame_cols_in;
         frame_rows_ff <= frame_rows_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         emit_col_ff   <= emit_col_in;
         emit_row_ff   <= emit_row_in;
         draining_ff   <= draining_in;
         s2_result_ff  <= s2_result_in;
         s2_shift_ff   <= s2_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_inner_ff    <= inner;
         s2_bit_ff      <= pixel_bit;
         s2_col_ff      <= in_col_ff;
         s2_row_ff      <= emit_row_ff;
         s2_emit_col_ff <= emit_col_ff;
         s2_last_ff     <= draining_ff && last;
      end
   end

   // line store: read ahead at acceptance, write back in the second stage
   always_ff @(posedge clock) begin
      if (accept && do_store) begin
         rd_data_ff <= line_store[rd_addr];
      end
      if (s2_shift_ff) begin
         line_store[s2_col_ff] <= {window_ff[2][2:0], s2_bit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_shift_ff) begin
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= window_ff[3];
         window_ff[3] <= rd_data_ff;
      end
   end

   // bit 1 of each column word is the center row
   assign center_row_window = {rd_data_ff[1], window_ff[3][1], window_ff[2][1],
                               window_ff[1][1], window_ff[0][1]};
   assign vert = window_ff[2][3] & window_ff[2][2] & window_ff[2][0] & s2_bit_ff;

   always_comb begin
      s2_rsp.pixel_out     = (!s2_inner_ff || (vert && (&center_row_window)))
                             ? PIXEL_ON : PIXEL_OFF;
      s2_rsp.out_row       = OUT_ROW_WIDTH'(s2_row_ff);
      s2_rsp.out_col       = OUT_COL_WIDTH'(s2_emit_col_ff);
      s2_rsp.last_of_frame = s2_last_ff;
   end

   assign push = s2_result_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_queue_ff[wr_ptr_ff] <= s2_rsp;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = rsp_queue_ff[rd_ptr_ff];

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= (QCW+1)'(RSP_DEPTH))
      else $error("result queue overcommitted");

   a_drain_col: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> in_col_ff == '0)
      else $error("draining with a partial input row");

   a_emit_lag: assert property (@(posedge clock) disable iff (reset)
      (!draining_ff && in_row_ff >= RW'(2))
      |-> (emit_col_ff == in_col_ff && RW'(emit_row_ff) + RW'(2) == in_row_ff))
      else $error("output position not two rows behind input");

   a_store_follows_accept: assert property (@(posedge clock) disable iff (reset)
      s2_shift_ff |-> $past(accept && do_store))
      else $error("line store write without a pixel transaction");

   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_frame) |-> rsp_data.pixel_out == PIXEL_ON)
      else $error("last pixel of frame not on the border");

endmodule
